FILE: src/srp_pkg.sv
`timescale 1ns / 1ps

package srp_pkg;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 128;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_RATE  = 2'd1;
  localparam logic [1:0] KIND_APPLY = 2'd2;
  localparam logic [1:0] KIND_READ  = 2'd3;

  localparam logic [1:0] REGION_SURFACE = 2'd0;
  localparam logic [1:0] REGION_INNER   = 2'd1;
  localparam logic [1:0] REGION_OUTER   = 2'd2;

  localparam logic [1:0] SIDE_INNER = 2'd0;
  localparam logic [1:0] SIDE_OUTER = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_RATE_CONSTANT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME_SIDE   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ORDER     = 2'd1;
  localparam logic [1:0] ST_COUNT_SAT = 2'd2;
  localparam logic [1:0] ST_PROD_SAT  = 2'd3;

  typedef enum logic [2:0] {
    OP_WRITE     = 3'd0,
    OP_TERM      = 3'd1,
    OP_SKIP      = 3'd2,
    OP_ORDER_ERR = 3'd3,
    OP_SHORT     = 3'd4,
    OP_APPLY     = 3'd5,
    OP_READ      = 3'd6
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              last;
    logic              idx_ok;
    logic [1:0]        region;
    logic [5:0]        species;
    logic [31:0]       count_value;
    logic [2:0]        order;
    logic signed [4:0] change;
    logic              clamped;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctrl_t;

  typedef struct packed {
    logic [63:0] rate_constant;
    logic        reaction_active;
    logic [1:0]  volume_side;
  } cfg_t;

endpackage

FILE: src/surface_reaction_propensity.sv
`timescale 1ns / 1ps

// Mass-action propensity engine over three molecule pools (surface, inner, outer), each
// SPECIES counts deep, kept in one pool RAM. After reset a clearing pass zeroes the pool
// with in_tready low; configuration writes are taken meanwhile. Requests are decoded
// into a two-entry queue and run one at a time by the back end, whose speed is set by
// the single shared 32x32 multiplier: a count write goes straight to the pool, a read
// or apply first reads the pool, a rate term of order n takes n multiplications, and a
// last term of an active reaction adds the Q32.32 scaling by the rate constant. Results
// leave through an output register, so the next request is taken while a result waits.
module surface_reaction_propensity #(
  parameter int SPECIES   = 64,
  parameter int MAX_ORDER = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // region, species, count_value, order, change, clamped, zero fill
  input  logic [srp_pkg::IN_DATA_W-1:0]    in_tdata,
  // kind
  input  logic [1:0]                       in_tuser,
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // propensity, count_out, firings
  output logic [srp_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status
  output logic [1:0]                       out_tuser,
  input  logic                             cfg_we,
  input  logic [srp_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [srp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  import srp_pkg::*;

  logic [63:0] rate_constant_r;
  logic        reaction_active_r;
  logic [1:0]  volume_side_r;
  cfg_t        cfg;
  q_head_t     head;
  back_ctrl_t  ctrl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_constant_r   <= 64'd0;
      reaction_active_r <= 1'b1;
      volume_side_r     <= SIDE_INNER;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_RATE_CONSTANT: rate_constant_r   <= cfg_wdata;
        REG_ACTIVE:        reaction_active_r <= cfg_wdata[0];
        REG_VOLUME_SIDE:   volume_side_r     <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  assign cfg.rate_constant   = rate_constant_r;
  assign cfg.reaction_active = reaction_active_r;
  assign cfg.volume_side     = volume_side_r;

  srp_front #(.SPECIES(SPECIES), .MAX_ORDER(MAX_ORDER)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cfg       (cfg),
    .ctrl      (ctrl),
    .head      (head)
  );

  srp_back #(.SPECIES(SPECIES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head       (head),
    .ctrl       (ctrl),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: src/srp_ram.sv
`timescale 1ns / 1ps

module srp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 192
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/srp_front.sv
`timescale 1ns / 1ps

module srp_front #(
  parameter int SPECIES   = 64,
  parameter int MAX_ORDER = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [srp_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]                     in_tuser,
  input  logic                           in_tlast,
  input  srp_pkg::cfg_t                  cfg,
  input  srp_pkg::back_ctrl_t            ctrl,
  output srp_pkg::q_head_t               head
);

  import srp_pkg::*;

  logic [1:0]        in_region;
  logic [5:0]        in_species;
  logic [31:0]       in_count;
  logic [2:0]        in_order;
  logic signed [4:0] in_change;
  logic              in_clamped;
  logic              idx_ok;
  logic              counted;
  logic              push;
  q_item_t           item;

  q_item_t           q_mem_r [QDEPTH];
  logic [QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]    q_count_r, q_count_nxt;

  assign in_region  = in_tdata[1:0];
  assign in_species = in_tdata[7:2];
  assign in_count   = in_tdata[39:8];
  assign in_order   = in_tdata[42:40];
  assign in_change  = $signed(in_tdata[47:43]);
  assign in_clamped = in_tdata[48];

  assign idx_ok  = (in_region <= REGION_OUTER) && (int'(in_species) < SPECIES);
  assign counted = (in_region == REGION_SURFACE) ||
                   (in_region == REGION_INNER && cfg.volume_side == SIDE_INNER) ||
                   (in_region == REGION_OUTER && cfg.volume_side == SIDE_OUTER);

  // classify the request
  always_comb begin
    item.last        = in_tlast;
    item.idx_ok      = idx_ok;
    item.region      = in_region;
    item.species     = in_species;
    item.count_value = in_count;
    item.order       = in_order;
    item.change      = in_change;
    item.clamped     = in_clamped;
    case (in_tuser)
      KIND_WRITE: item.op = OP_WRITE;
      KIND_RATE: begin
        if (in_order == 3'd0) begin
          item.op = OP_SKIP;
        end else if (int'(in_order) > MAX_ORDER) begin
          item.op = OP_ORDER_ERR;
        end else if (!idx_ok || !counted) begin
          item.op = OP_SHORT;
        end else begin
          item.op = OP_TERM;
        end
      end
      KIND_APPLY: item.op = OP_APPLY;
      default:    item.op = OP_READ;
    endcase
  end

  assign in_tready = (q_count_r != QCW'(QDEPTH)) && !ctrl.clearing;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    wr_ptr_nxt  = wr_ptr_r;
    rd_ptr_nxt  = rd_ptr_r;
    q_count_nxt = q_count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + QAW'(1);
    end
    if (ctrl.pop) begin
      rd_ptr_nxt = rd_ptr_r + QAW'(1);
    end
    if (push && !ctrl.pop) begin
      q_count_nxt = q_count_r + QCW'(1);
    end else if (!push && ctrl.pop) begin
      q_count_nxt = q_count_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      q_count_r <= '0;
    end else begin
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      q_count_r <= q_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item;
    end
  end

  assign head.valid = (q_count_r != '0);
  assign head.item  = q_mem_r[rd_ptr_r];

`ifndef SYNTHESIS
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop |-> q_count_r != '0)
    else $error("pop from empty queue");
`endif

endmodule

FILE: src/srp_back.sv
`timescale 1ns / 1ps

module srp_back #(
  parameter int SPECIES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  srp_pkg::cfg_t                   cfg,
  input  srp_pkg::q_head_t                head,
  output srp_pkg::back_ctrl_t             ctrl,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [srp_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [1:0]                      out_tuser
);

  import srp_pkg::*;

  localparam int DEPTH = 3 * SPECIES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_READ = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_POST = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  q_item_t       item_r, item_nxt;
  logic [31:0]   cnt_r, cnt_nxt;
  logic [2:0]    k_r, k_nxt;
  logic [63:0]   prod_r, prod_nxt;
  logic          short_r, short_nxt;
  logic          oerr_r, oerr_nxt;
  logic          psat_r, psat_nxt;
  logic [31:0]   fire_r, fire_nxt;
  logic [63:0]   mul_a_r, mul_a_nxt;
  logic [63:0]   mul_b_r, mul_b_nxt;
  logic          final_r, final_nxt;
  logic [2:0]    step_r, step_nxt;
  logic [127:0]  acc_r, acc_nxt;
  logic [63:0]   pp_r, pp_nxt;
  logic [1:0]    sh_r, sh_nxt;
  logic [63:0]   res_prop_r, res_prop_nxt;
  logic [31:0]   res_cnt_r, res_cnt_nxt;
  logic [1:0]    res_st_r, res_st_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [63:0]   out_prop_r, out_prop_nxt;
  logic [31:0]   out_cnt_r, out_cnt_nxt;
  logic [1:0]    out_st_r, out_st_nxt;
  logic [31:0]   out_fire_r, out_fire_nxt;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [31:0]       ram_wdata, ram_rdata;
  logic [AW-1:0]     head_addr, cur_addr;
  logic [31:0]       cur_cnt;
  logic signed [33:0] apply_sum;
  logic              apply_do;
  logic [2:0]        nsteps;
  logic [31:0]       a_sel, b_sel;
  logic [127:0]      pp_shifted;
  logic [63:0]       prod_new;
  logic              prod_ovf;
  logic              final_ovf;
  logic [2:0]        k_inc;
  logic              pop;

  srp_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_pool (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign head_addr = AW'(int'(head.item.region) * SPECIES + int'(head.item.species));
  assign cur_addr  = AW'(int'(item_r.region) * SPECIES + int'(item_r.species));
  assign cur_cnt   = item_r.idx_ok ? ram_rdata : 32'd0;
  assign apply_sum = $signed({2'b00, cur_cnt}) +
                     $signed({{29{item_r.change[4]}}, item_r.change});
  assign apply_do  = item_r.idx_ok && !item_r.clamped && (item_r.change != 5'sd0);

  // shared 32x32 multiplier, partial products accumulated over cycles
  assign nsteps = final_r ? 3'd4 : 3'd2;
  assign a_sel  = step_r[0] ? mul_a_r[63:32] : mul_a_r[31:0];
  assign b_sel  = step_r[1] ? mul_b_r[63:32] : mul_b_r[31:0];

  always_comb begin
    case (sh_r)
      2'd0:    pp_shifted = {64'd0, pp_r};
      2'd1:    pp_shifted = {32'd0, pp_r, 32'd0};
      2'd2:    pp_shifted = {pp_r, 64'd0};
      default: pp_shifted = '0;
    endcase
  end

  assign prod_ovf  = (acc_r[127:64] != 64'd0);
  assign prod_new  = prod_ovf ? '1 : acc_r[63:0];
  assign final_ovf = (acc_r[127:96] != 32'd0);
  assign k_inc     = k_r + 3'd1;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    item_nxt      = item_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    prod_nxt      = prod_r;
    short_nxt     = short_r;
    oerr_nxt      = oerr_r;
    psat_nxt      = psat_r;
    fire_nxt      = fire_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    final_nxt     = final_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    pp_nxt        = pp_r;
    sh_nxt        = sh_r;
    res_prop_nxt  = res_prop_r;
    res_cnt_nxt   = res_cnt_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_prop_nxt  = out_prop_r;
    out_cnt_nxt   = out_cnt_r;
    out_st_nxt    = out_st_r;
    out_fire_nxt  = out_fire_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = cur_addr;
    ram_wdata     = 32'd0;
    ram_raddr     = head_addr;
    pop           = 1'b0;

    case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (head.valid) begin
          pop      = 1'b1;
          item_nxt = head.item;
          case (head.item.op)
            OP_WRITE: begin
              ram_we    = head.item.idx_ok;
              ram_waddr = head_addr;
              ram_wdata = head.item.count_value;
            end
            OP_SKIP, OP_ORDER_ERR, OP_SHORT: begin
              if (head.item.op == OP_ORDER_ERR) begin
                oerr_nxt = 1'b1;
              end
              if (head.item.op == OP_SHORT) begin
                short_nxt = 1'b1;
              end
              if (head.item.last) begin
                state_nxt = S_FIN;
              end
            end
            OP_TERM, OP_APPLY, OP_READ: begin
              ram_re    = head.item.idx_ok;
              state_nxt = S_READ;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        cnt_nxt = cur_cnt;
        case (item_r.op)
          OP_READ: begin
            res_prop_nxt = 64'd0;
            res_cnt_nxt  = cur_cnt;
            res_st_nxt   = ST_OK;
            state_nxt    = S_OUT;
          end
          OP_APPLY: begin
            res_prop_nxt = 64'd0;
            res_cnt_nxt  = cur_cnt;
            res_st_nxt   = ST_OK;
            if (apply_do) begin
              if (apply_sum[33]) begin
                res_cnt_nxt = 32'd0;
                res_st_nxt  = ST_COUNT_SAT;
              end else if (apply_sum[32]) begin
                res_cnt_nxt = '1;
                res_st_nxt  = ST_COUNT_SAT;
              end else begin
                res_cnt_nxt = apply_sum[31:0];
              end
              ram_we    = 1'b1;
              ram_wdata = res_cnt_nxt;
            end
            if (item_r.last) begin
              fire_nxt = fire_r + 32'd1;
            end
            state_nxt = S_OUT;
          end
          OP_TERM: begin
            if (cur_cnt < 32'(item_r.order)) begin
              short_nxt = 1'b1;
              state_nxt = item_r.last ? S_FIN : S_IDLE;
            end else begin
              mul_a_nxt = prod_r;
              mul_b_nxt = {32'd0, cur_cnt};
              k_nxt     = 3'd0;
              final_nxt = 1'b0;
              step_nxt  = 3'd0;
              acc_nxt   = '0;
              state_nxt = S_MUL;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_MUL: begin
        pp_nxt   = a_sel * b_sel;
        sh_nxt   = {1'b0, step_r[0]} + {1'b0, step_r[1]};
        step_nxt = step_r + 3'd1;
        if (step_r != 3'd0) begin
          acc_nxt = acc_r + pp_shifted;
        end
        if (step_r == nsteps) begin
          state_nxt = S_POST;
        end
      end
      S_POST: begin
        if (final_r) begin
          res_prop_nxt = final_ovf ? '1 : acc_r[95:32];
          res_st_nxt   = (final_ovf || psat_r) ? ST_PROD_SAT : ST_OK;
          res_cnt_nxt  = 32'd0;
          prod_nxt     = 64'd1;
          short_nxt    = 1'b0;
          oerr_nxt     = 1'b0;
          psat_nxt     = 1'b0;
          final_nxt    = 1'b0;
          state_nxt    = S_OUT;
        end else begin
          prod_nxt = prod_new;
          if (prod_ovf) begin
            psat_nxt = 1'b1;
          end
          k_nxt = k_inc;
          if (k_inc < item_r.order) begin
            mul_a_nxt = prod_new;
            mul_b_nxt = {32'd0, cnt_r - 32'(k_inc)};
            step_nxt  = 3'd0;
            acc_nxt   = '0;
            state_nxt = S_MUL;
          end else begin
            state_nxt = item_r.last ? S_FIN : S_IDLE;
          end
        end
      end
      S_FIN: begin
        res_prop_nxt = 64'd0;
        res_cnt_nxt  = 32'd0;
        res_st_nxt   = ST_OK;
        if (cfg.reaction_active && !oerr_r && !short_r) begin
          mul_a_nxt = prod_r;
          mul_b_nxt = cfg.rate_constant;
          final_nxt = 1'b1;
          step_nxt  = 3'd0;
          acc_nxt   = '0;
          state_nxt = S_MUL;
        end else begin
          if (cfg.reaction_active && oerr_r) begin
            res_st_nxt = ST_ORDER;
          end
          prod_nxt  = 64'd1;
          short_nxt = 1'b0;
          oerr_nxt  = 1'b0;
          psat_nxt  = 1'b0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_prop_nxt  = res_prop_r;
          out_cnt_nxt   = res_cnt_r;
          out_st_nxt    = res_st_r;
          out_fire_nxt  = fire_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      k_r         <= '0;
      prod_r      <= 64'd1;
      short_r     <= 1'b0;
      oerr_r      <= 1'b0;
      psat_r      <= 1'b0;
      fire_r      <= '0;
      final_r     <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      k_r         <= k_nxt;
      prod_r      <= prod_nxt;
      short_r     <= short_nxt;
      oerr_r      <= oerr_nxt;
      psat_r      <= psat_nxt;
      fire_r      <= fire_nxt;
      final_r     <= final_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    cnt_r      <= cnt_nxt;
    mul_a_r    <= mul_a_nxt;
    mul_b_r    <= mul_b_nxt;
    acc_r      <= acc_nxt;
    pp_r       <= pp_nxt;
    sh_r       <= sh_nxt;
    res_prop_r <= res_prop_nxt;
    res_cnt_r  <= res_cnt_nxt;
    res_st_r   <= res_st_nxt;
    out_prop_r <= out_prop_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_st_r   <= out_st_nxt;
    out_fire_r <= out_fire_nxt;
  end

  assign ctrl.pop      = pop;
  assign ctrl.clearing = (state_r == S_CLR);
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = {out_fire_r, out_cnt_r, out_prop_r};
  assign out_tuser     = out_st_r;

`ifndef SYNTHESIS
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("pool read and write in one cycle");

  a_fire_on_apply: assert property (@(posedge clk) disable iff (!rst_n)
    fire_r != $past(fire_r) |->
      $past(state_r == S_READ && item_r.op == OP_APPLY && item_r.last))
    else $error("firing count moved outside an apply");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL |-> step_r <= nsteps)
    else $error("multiplier step out of range");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result shown without passing the output state");
`endif

endmodule
